// ===== design/hdt_pkg.sv =====
// ----------------------------------------------------------------------------
// hdt_pkg
// shared types and constants for the header/trailer deframer
// ----------------------------------------------------------------------------
package hdt_pkg;

    localparam int unsigned ByteW = 8;
    localparam int unsigned CfgIdxW = 2;

    // configuration register indexes
    localparam logic [CfgIdxW-1:0] CFG_HEADER_FIRST   = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_HEADER_SECOND  = 2'd1;
    localparam logic [CfgIdxW-1:0] CFG_TRAILER_FIRST  = 2'd2;
    localparam logic [CfgIdxW-1:0] CFG_TRAILER_SECOND = 2'd3;

    // marker values after reset
    localparam logic [ByteW-1:0] RST_HEADER_FIRST   = 8'hEB;
    localparam logic [ByteW-1:0] RST_HEADER_SECOND  = 8'h99;
    localparam logic [ByteW-1:0] RST_TRAILER_FIRST  = 8'h99;
    localparam logic [ByteW-1:0] RST_TRAILER_SECOND = 8'hBE;

    typedef enum logic [1:0] {
        PH_HUNT  = 2'd0,
        PH_HALF  = 2'd1,
        PH_FRAME = 2'd2
    } phase_t;

    typedef struct packed {
        logic [ByteW-1:0] header_first;
        logic [ByteW-1:0] header_second;
        logic [ByteW-1:0] trailer_first;
        logic [ByteW-1:0] trailer_second;
    } hdt_cfg_t;

    typedef struct packed {
        logic             has_result;
        logic [ByteW-1:0] out_byte;
        logic             frame_end;
    } hdt_result_t;

endpackage

// ===== design/hdt_cfg.sv =====
// ----------------------------------------------------------------------------
// hdt_cfg
// marker byte registers, written through a plain write port
// ----------------------------------------------------------------------------
module hdt_cfg
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [hdt_pkg::CfgIdxW-1:0]   cfg_index,
    input  logic [hdt_pkg::ByteW-1:0]     cfg_data,
    output hdt_pkg::hdt_cfg_t             cfg
);
    import hdt_pkg::*;

    hdt_cfg_t cfg_reg;
    hdt_cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_HEADER_FIRST:   cfg_next.header_first   = cfg_data;
                CFG_HEADER_SECOND:  cfg_next.header_second  = cfg_data;
                CFG_TRAILER_FIRST:  cfg_next.trailer_first  = cfg_data;
                CFG_TRAILER_SECOND: cfg_next.trailer_second = cfg_data;
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.header_first   <= RST_HEADER_FIRST;
            cfg_reg.header_second  <= RST_HEADER_SECOND;
            cfg_reg.trailer_first  <= RST_TRAILER_FIRST;
            cfg_reg.trailer_second <= RST_TRAILER_SECOND;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== design/hdt_step.sv =====
// ----------------------------------------------------------------------------
// hdt_step
// framing state and the per-byte decision, one byte per cycle while fire is high
// ----------------------------------------------------------------------------
module hdt_step
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       fire,
    input  logic [hdt_pkg::ByteW-1:0]  in_byte,
    input  hdt_pkg::hdt_cfg_t          cfg,
    output hdt_pkg::hdt_result_t       res
);
    import hdt_pkg::*;

    phase_t           phase_reg;
    phase_t           phase_next;
    logic [ByteW-1:0] held_byte_reg;
    logic [ByteW-1:0] held_byte_next;
    logic             held_valid_reg;
    logic             held_valid_next;

    always_comb
    begin
        phase_next      = phase_reg;
        held_byte_next  = held_byte_reg;
        held_valid_next = held_valid_reg;
        res             = '0;
        case (phase_reg)
            PH_FRAME:
            begin
                if (held_valid_reg && held_byte_reg == cfg.trailer_first
                    && in_byte == cfg.trailer_second)
                begin
                    res.has_result  = 1'b1;
                    res.frame_end   = 1'b1;
                    phase_next      = PH_HUNT;
                    held_valid_next = 1'b0;
                end
                else if (held_valid_reg)
                begin
                    res.has_result = 1'b1;
                    res.out_byte   = held_byte_reg;
                    held_byte_next = in_byte;
                end
                else
                begin
                    held_byte_next  = in_byte;
                    held_valid_next = 1'b1;
                end
            end
            PH_HALF:
            begin
                if (in_byte == cfg.header_second)
                begin
                    phase_next      = PH_FRAME;
                    held_valid_next = 1'b0;
                end
                else if (in_byte == cfg.header_first)
                begin
                    phase_next = PH_HALF;
                end
                else
                begin
                    phase_next = PH_HUNT;
                end
            end
            default:
            begin
                // hunting, also covers the unused phase code
                phase_next = (in_byte == cfg.header_first) ? PH_HALF : PH_HUNT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_HUNT;
            held_byte_reg  <= '0;
            held_valid_reg <= 1'b0;
        end
        else if (fire)
        begin
            phase_reg      <= phase_next;
            held_byte_reg  <= held_byte_next;
            held_valid_reg <= held_valid_next;
        end
    end

endmodule

// ===== design/header_trailer_deframer_unit.sv =====
// ----------------------------------------------------------------------------
// header_trailer_deframer_unit
// extracts framed payload bytes from a raw byte stream
// ----------------------------------------------------------------------------
// path: an accepted byte waits in the input register, then passes through the framing step into the result register
// throughput: one byte per cycle while the result register is not stalled, set by the framing state loop
// a full, stalled result register holds the input register, which then raises in_stall while it holds a byte
// reset: async active low; hunting for a header, no byte held, markers at
//   their default values, both pipeline registers empty
// ----------------------------------------------------------------------------
module header_trailer_deframer_unit
(
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration write port
    input  logic                          cfg_wr_en,
    input  logic [hdt_pkg::CfgIdxW-1:0]   cfg_index,
    input  logic [hdt_pkg::ByteW-1:0]     cfg_data,
    // received byte channel
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [hdt_pkg::ByteW-1:0]     rx_byte,
    // result channel
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [hdt_pkg::ByteW-1:0]     out_byte,
    output logic                          frame_end
);
    import hdt_pkg::*;

    hdt_cfg_t         cfg;
    hdt_result_t      res;

    // input register
    logic             in_valid_reg;
    logic             in_valid_next;
    logic [ByteW-1:0] in_byte_reg;
    logic [ByteW-1:0] in_byte_next;

    // result register
    logic             out_valid_reg;
    logic             out_valid_next;
    logic [ByteW-1:0] out_byte_reg;
    logic [ByteW-1:0] out_byte_next;
    logic             frame_end_reg;
    logic             frame_end_next;

    logic             in_take;
    logic             advance;
    logic             out_free;

    hdt_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    hdt_step u_step
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .fire    (advance),
        .in_byte (in_byte_reg),
        .cfg     (cfg),
        .res     (res)
    );

    // result register can take a new item when empty or being drained
    assign out_free = !out_valid_reg || !out_stall;
    // held item moves through the framing logic into the result register
    assign advance  = in_valid_reg && out_free;
    // input register is free when empty or its item moves on this cycle
    assign in_stall = in_valid_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        in_byte_next  = in_byte_reg;
        if (in_take)
        begin
            in_valid_next = 1'b1;
            in_byte_next  = rx_byte;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        frame_end_next = frame_end_reg;
        if (out_free)
        begin
            // not every byte yields an item: hunting and holding give none
            out_valid_next = advance && res.has_result;
            out_byte_next  = res.out_byte;
            frame_end_next = res.frame_end;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_byte_reg   <= in_byte_next;
        out_byte_reg  <= out_byte_next;
        frame_end_reg <= frame_end_next;
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign frame_end = frame_end_reg;

    // an end-of-frame item never carries a payload byte
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && frame_end_reg |-> out_byte_reg == '0)
        else $error("end-of-frame item with non-zero byte");

    // nothing moves into a full result register that is stalled
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_stall |-> !advance)
        else $error("framing step fired into a stalled result register");

    // stall is only raised while an item waits in the input register
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> in_valid_reg)
        else $error("input stalled with empty input register");

    // an item left in the input register without moving is still there
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_byte_reg))
        else $error("held input item lost");

endmodule
